// ===== src/magnetic_knob_angle_delta_assert.svh =====
`ifndef MAGNETIC_KNOB_ANGLE_DELTA_ASSERT_SVH
`define MAGNETIC_KNOB_ANGLE_DELTA_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MKAD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mkad assertion failed");

// Next-cycle implication, disabled during reset.
`define MKAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mkad assertion failed");

`endif

// ===== src/mkad_pkg.sv =====
package mkad_pkg;

  localparam int SETTLE_SAMPLES_DEF = 5;
  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF    = 2;

  localparam int FIELD_W    = 16;
  localparam int ANGLE_W    = 16;
  localparam int DEADBAND_W = 14;
  localparam int COUNT_W    = 8;
  // x*256 after rotation gain stays well inside 26 bits; two spare
  localparam int VEC_W      = 28;
  localparam int Z_W        = 32;

  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 14'd182;
  localparam logic [ANGLE_W-1:0]    ANGLE_ZERO_VEC = 16'h8000;
  localparam logic [Z_W-1:0]        Z_HALF_TURN    = 32'h8000_0000;
  // half turn offset plus rounding of the low 16 bits
  localparam logic [Z_W-1:0]        Z_OUT_OFFSET   = 32'h8000_8000;

  typedef enum logic [1:0] {
    F_IDLE,
    F_ITER,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic               valid;
    logic [ANGLE_W-1:0] angle;
  } angle_item_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [Z_W-1:0] atan_turn(input logic [4:0] idx);
    logic [Z_W-1:0] r;
    case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      5'd20:   r = 32'h0000_028C;
      5'd21:   r = 32'h0000_0146;
      5'd22:   r = 32'h0000_00A3;
      5'd23:   r = 32'h0000_0051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/mkad_if.sv =====
interface mkad_sample_if;
  import mkad_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [FIELD_W-1:0] field_x;
  logic signed [FIELD_W-1:0] field_y;

  modport source (output valid, output field_x, output field_y, input ready);
  modport sink   (input valid, input field_x, input field_y, output ready);
endinterface

interface mkad_result_if;
  import mkad_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [ANGLE_W-1:0] angle_delta;
  logic               moved;
  logic               settling;

  modport source (output valid, output angle_delta, output moved, output settling,
                  input ready);
  modport sink   (input valid, input angle_delta, input moved, input settling,
                  output ready);
endinterface

// ===== src/mkad_cordic.sv =====
module mkad_cordic #(
  parameter int CORDIC_STAGES = mkad_pkg::CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  mkad_sample_if.sink           sample,
  input  logic                  queue_full,
  output mkad_pkg::angle_item_t push
);
  import mkad_pkg::*;

  localparam int IW = $clog2(CORDIC_STAGES);

  front_state_t state, state_next;

  logic signed [VEC_W-1:0] vx, vy;
  logic [Z_W-1:0]          z;
  logic [IW-1:0]           iter;
  logic                    zero_vec;

  logic                    take;
  logic                    last_iter;
  logic signed [16:0]      nx, ny, lx, ly;
  logic signed [VEC_W-1:0] sx, sy;
  logic [Z_W-1:0]          z_out, step_atan;

  assign take      = sample.valid && sample.ready;
  assign last_iter = (iter == IW'(CORDIC_STAGES - 1));

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (sample.valid) begin
          if (sample.field_x == '0 && sample.field_y == '0) state_next = F_PUSH;
          else state_next = F_ITER;
        end
      end
      F_ITER: begin
        if (last_iter) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!queue_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = (state == F_IDLE);
    push.valid   = (state == F_PUSH) && !queue_full;
    push.angle   = zero_vec ? ANGLE_ZERO_VEC : z_out[Z_W-1:Z_W-ANGLE_W];
  end

  assign z_out = z + Z_OUT_OFFSET;

  // operand is (x, -y); left half plane is turned by half a turn first
  always_comb begin
    nx = {sample.field_x[FIELD_W-1], sample.field_x};
    ny = -{sample.field_y[FIELD_W-1], sample.field_y};
    if (sample.field_x[FIELD_W-1]) begin
      lx = -nx;
      ly = -ny;
    end else begin
      lx = nx;
      ly = ny;
    end
  end

  assign sx        = vx >>> iter;
  assign sy        = vy >>> iter;
  assign step_atan = atan_turn(5'(iter));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      vx       <= {{(VEC_W-17){lx[16]}}, lx} <<< 8;
      vy       <= {{(VEC_W-17){ly[16]}}, ly} <<< 8;
      z        <= sample.field_x[FIELD_W-1] ? Z_HALF_TURN : '0;
      iter     <= '0;
      zero_vec <= (sample.field_x == '0 && sample.field_y == '0);
    end else if (state == F_ITER) begin
      if (vy > 0) begin
        vx <= vx + sy;
        vy <= vy - sx;
        z  <= z + step_atan;
      end else begin
        vx <= vx - sy;
        vy <= vy + sx;
        z  <= z - step_atan;
      end
      iter <= iter + 1'b1;
    end
  end

endmodule

// ===== src/mkad_queue.sv =====
module mkad_queue #(
  parameter int DEPTH = mkad_pkg::QUEUE_DEPTH_DEF  // 2 or more
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mkad_pkg::angle_item_t push,
  output logic                  full,
  output mkad_pkg::angle_item_t head,
  input  logic                  pop
);
  import mkad_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [ANGLE_W-1:0] mem [DEPTH];
  logic [PW-1:0]      wr_ptr, rd_ptr;
  logic [CW-1:0]      count;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.angle = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.angle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/mkad_delta.sv =====
module mkad_delta #(
  parameter int SETTLE_SAMPLES = mkad_pkg::SETTLE_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mkad_pkg::DEADBAND_W-1:0]   cfg_wdata,
  input  mkad_pkg::angle_item_t             head,
  output logic                              pop,
  mkad_result_if.source                     result
);
  import mkad_pkg::*;

  logic [DEADBAND_W-1:0] deadband;
  logic [ANGLE_W-1:0]    last_angle;
  logic [COUNT_W-1:0]    settle_count;
  logic                  out_valid;

  logic               settling_now;
  logic [ANGLE_W-1:0] diff, mag;
  logic               over;

  assign pop          = head.valid && (!out_valid || result.ready);
  assign settling_now = (settle_count < COUNT_W'(SETTLE_SAMPLES));
  assign diff         = head.angle - last_angle;
  // half-turn difference gives 0x8000, read as 32768
  assign mag          = diff[ANGLE_W-1] ? (~diff + 1'b1) : diff;
  assign over         = (mag > {{(ANGLE_W-DEADBAND_W){1'b0}}, deadband});
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband     <= DEADBAND_RESET;
      last_angle   <= '0;
      settle_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) deadband <= cfg_wdata;
      if (pop) begin
        out_valid <= 1'b1;
        if (settling_now) begin
          last_angle   <= head.angle;
          settle_count <= settle_count + 1'b1;
        end else if (over) begin
          last_angle <= head.angle;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.settling    <= settling_now;
      result.moved       <= !settling_now && over;
      result.angle_delta <= (!settling_now && over) ? diff : '0;
    end
  end

endmodule

// ===== src/magnetic_knob_angle_delta.sv =====
// Magnetic knob angle delta. Each sample (field_x, field_y) is turned into an
// absolute angle atan2(-y, x) + half a turn, 65536 units per turn, by one shared
// CORDIC stage that runs CORDIC_STAGES times. The front end takes a sample in
// F_IDLE, iterates in F_ITER unless both fields are zero, pushes in F_PUSH and
// only then takes the next, so the CORDIC loop sets the sustained rate. Angles
// pass a QUEUE_DEPTH entry queue to the delta stage, which registers and holds
// the result; a stalled result fills the queue, then stalls F_PUSH. The first
// SETTLE_SAMPLES results carry settling = 1 and zero delta; later ones report
// the wrapped change from the last reported angle when it exceeds deadband
// (moved = 1), otherwise zero. Write deadband only while the block is idle.
module magnetic_knob_angle_delta #(
  parameter int SETTLE_SAMPLES = mkad_pkg::SETTLE_SAMPLES_DEF,
  parameter int CORDIC_STAGES  = mkad_pkg::CORDIC_STAGES_DEF,
  parameter int QUEUE_DEPTH    = mkad_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mkad_pkg::DEADBAND_W-1:0] cfg_wdata,
  mkad_sample_if.sink                     sample,
  mkad_result_if.source                   result
);
  import mkad_pkg::*;

  angle_item_t push, head;
  logic        queue_full;
  logic        pop;

  mkad_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .queue_full(queue_full),
    .push      (push)
  );

  mkad_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .push(push),
    .full(queue_full),
    .head(head),
    .pop (pop)
  );

  mkad_delta #(
    .SETTLE_SAMPLES(SETTLE_SAMPLES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .head     (head),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ===== src/mkad_checker.sv =====
`include "magnetic_knob_angle_delta_assert.svh"

module mkad_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] angle_delta,
  input logic        moved,
  input logic        settling
);

  // a pending result stays until transferred
  `MKAD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `MKAD_ASSERT_NOW(a_flags_excl, clk, rst, out_valid, !(moved && settling))
  `MKAD_ASSERT_NOW(a_still_zero, clk, rst, out_valid && !moved, angle_delta == 16'd0)
  // a reported move is always larger than a deadband of at least zero
  `MKAD_ASSERT_NOW(a_moved_nonzero, clk, rst, out_valid && moved, angle_delta != 16'd0)

endmodule

bind magnetic_knob_angle_delta mkad_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .angle_delta(result.angle_delta),
  .moved      (result.moved),
  .settling   (result.settling)
);

// ===== tb/sv/tb_magnetic_knob_angle_delta.sv =====
module tb_magnetic_knob_angle_delta;
  timeunit 1ns;
  timeprecision 1ps;
  import mkad_pkg::*;

  // atan(2^-i), 2^32 units per turn
  localparam logic [31:0] ATAN_STEP [0:23] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  typedef struct {
    logic signed [15:0] delta;
    logic               moved;
    logic               settling;
  } knob_result_t;

  class angle_delta_tracker;
    int unsigned  deadband;
    logic [15:0]  last_angle;
    int unsigned  settle_count;
    knob_result_t pending_deltas[$];
    int           errors;

    function new();
      deadband     = 182;
      last_angle   = '0;
      settle_count = 0;
      errors       = 0;
    endfunction

    // vectoring CORDIC, absolute angle atan2(ny, nx) + half turn
    function logic [15:0] cordic_angle(int nx, int ny);
      longint vx, vy, sx, sy;
      logic [31:0] z;
      if (nx == 0 && ny == 0) return 16'h8000;
      vx = longint'(nx) * 256;
      vy = longint'(ny) * 256;
      z  = '0;
      if (vx < 0) begin
        vx = -vx;
        vy = -vy;
        z  = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (vy > 0) begin
          vx = vx + sy;
          vy = vy - sx;
          z  = z + ATAN_STEP[i];
        end else begin
          vx = vx - sy;
          vy = vy + sx;
          z  = z - ATAN_STEP[i];
        end
      end
      z = z + 32'h8000_8000;
      return z[31:16];
    endfunction

    function void take_sample(logic signed [15:0] x, logic signed [15:0] y);
      logic [15:0]        angle;
      logic signed [15:0] sdiff;
      int                 mag;
      knob_result_t       r;
      angle = cordic_angle(int'(x), -int'(y));
      if (settle_count < SETTLE_SAMPLES_DEF) begin
        last_angle   = angle;
        settle_count = settle_count + 1;
        r = '{delta: '0, moved: 1'b0, settling: 1'b1};
      end else begin
        sdiff = angle - last_angle;
        mag   = (sdiff < 0) ? -int'(sdiff) : int'(sdiff);
        if (mag > int'(deadband)) begin
          last_angle = angle;
          r = '{delta: sdiff, moved: 1'b1, settling: 1'b0};
        end else begin
          r = '{delta: '0, moved: 1'b0, settling: 1'b0};
        end
      end
      pending_deltas.push_back(r);
    endfunction

    function void match_result(logic signed [15:0] delta, logic moved, logic settling);
      knob_result_t e;
      if (pending_deltas.size() == 0) begin
        $display("%0t: unexpected result delta %0d moved %0b settling %0b",
                 $time, delta, moved, settling);
        errors++;
        return;
      end
      e = pending_deltas.pop_front();
      if (delta !== e.delta) begin
        $display("%0t: angle_delta expected %0d actual %0d", $time, e.delta, delta);
        errors++;
      end
      if (moved !== e.moved) begin
        $display("%0t: moved expected %0b actual %0b", $time, e.moved, moved);
        errors++;
      end
      if (settling !== e.settling) begin
        $display("%0t: settling expected %0b actual %0b", $time, e.settling, settling);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [DEADBAND_W-1:0] cfg_wdata;

  mkad_sample_if sample_ch ();
  mkad_result_if result_ch ();

  magnetic_knob_angle_delta i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  angle_delta_tracker tracker = new();

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_len        = 0;
  int prev_x          = 0;
  int prev_y          = 0;

  int dir_x [20] = '{0, 32767, -32768, 0, 0, 32767, -32768, -32768, 32767, -1,
                     1, 0, 0, -20000, 0, -1, 1, 20000, 20000, -32768};
  int dir_y [20] = '{0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768, 0,
                     0, 0, 0, 0, 0, -1, 1, 0, 3, -1};
  int edge_vals [6] = '{0, 1, -1, 32767, -32768, -32767};
  int band_vals [8] = '{0, 16383, 182, -1, 1, -2, 16382, 40};

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    sample_ch.valid     = 1'b0;
    sample_ch.field_x   = '0;
    sample_ch.field_y   = '0;
    result_ch.ready     = 1'b0;
  end

  // receiver: long hold-off counted here, otherwise random stalls
  always @(negedge clk) begin
    if (hold_len > 0) begin
      result_ch.ready = 1'b0;
      hold_len = hold_len - 1;
    end else begin
      result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.match_result(result_ch.angle_delta, result_ch.moved, result_ch.settling);
  end

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // entered and left just after a falling edge
  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y);
    bit done;
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_ch.valid = 1'b0;
      @(negedge clk);
    end
    sample_ch.valid   = 1'b1;
    sample_ch.field_x = x;
    sample_ch.field_y = y;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      done = sample_ch.ready;
    end
    tracker.take_sample(x, y);
    prev_x = x;
    prev_y = y;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    sample_ch.valid = 1'b0;
    while (tracker.pending_deltas.size() != 0) @(negedge clk);
  endtask

  task automatic write_deadband(int unsigned v);
    cfg_we    = 1'b1;
    cfg_wdata = v[DEADBAND_W-1:0];
    tracker.deadband = v & 32'h3FFF;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // deadband equal to the change holds the angle, one less reports it
  task automatic deadband_edge(int x, int y);
    logic signed [15:0] d;
    int mag;
    d   = tracker.cordic_angle(x, -y) - tracker.last_angle;
    mag = (d < 0) ? -int'(d) : int'(d);
    if (mag < 1 || mag > 16383) return;
    write_deadband(mag);
    send_sample(clamp16(x), clamp16(y));
    wait_drain();
    write_deadband(mag - 1);
    send_sample(clamp16(x), clamp16(y));
    wait_drain();
  endtask

  // knob-like motion around the last sample, plus repeats, quarter and half turns, noise and edge values
  task automatic gen_random(int n);
    int kind, span, nx, ny;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        span = 1 << $urandom_range(12, 3);
        nx   = prev_x + int'($urandom_range(2 * span)) - span;
        ny   = prev_y + int'($urandom_range(2 * span)) - span;
      end else if (kind < 47) begin
        nx = prev_x;
        ny = prev_y;
      end else if (kind < 77) begin
        nx = int'($urandom_range(65535)) - 32768;
        ny = int'($urandom_range(65535)) - 32768;
      end else if (kind < 88) begin
        nx = -prev_y;
        ny = prev_x;
      end else if (kind < 93) begin
        nx = -prev_x;
        ny = -prev_y;
      end else begin
        nx = edge_vals[$urandom_range(5)];
        ny = edge_vals[$urandom_range(5)];
      end
      if ($urandom_range(99) < 2) wait_drain();
      send_sample(clamp16(nx), clamp16(ny));
    end
  endtask

  initial begin
    int band;
    int setting;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // settling window and field extremes at the reset deadband
    for (int i = 0; i < 20; i++)
      send_sample(clamp16(dir_x[i]), clamp16(dir_y[i]));
    wait_drain();

    deadband_edge(20000, 500);
    deadband_edge(20000, -3000);
    deadband_edge(-5000, 12000);

    setting = 0;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 54; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin sender_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int k = 0; k < 2; k++) begin
        band = band_vals[setting];
        if (band == -1) band = $urandom_range(1000);
        if (band == -2) band = $urandom_range(16383);
        setting++;
        wait_drain();
        write_deadband(band);
        gen_random(78);
      end
      if (mode == 0) begin
        // stall the result side long enough to back up the input
        hold_len = 300;
        gen_random(30);
        wait_drain();
      end
    end

    wait_drain();
    repeat (40) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending_deltas.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/mkad_pkg.sv
src/mkad_if.sv
src/mkad_cordic.sv
src/mkad_queue.sv
src/mkad_delta.sv
src/magnetic_knob_angle_delta.sv
src/mkad_checker.sv
tb/sv/tb_magnetic_knob_angle_delta.sv
